// File: src/shc_pkg.sv
package shc_pkg;

  localparam int unsigned ID_W      = 8;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned OUT_CNT_W = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 1'b1;

  // Limit values after reset.
  localparam logic signed [SAMPLE_W-1:0] LOW_LIMIT_RST  = -16'sd1000;
  localparam logic signed [SAMPLE_W-1:0] HIGH_LIMIT_RST = 16'sd1000;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_PROBLEMS = 2'd1,
    STATUS_DEFECT   = 2'd2
  } status_e;

endpackage

// File: src/sensor_health_classifier.sv
// Sensor health classifier. Each accepted word carries a sensor id and a
// signed 16-bit reading; one result word comes back per reading with the
// sensor's updated saturating total and out-of-range counts and its status
// (ok, some bad readings, all readings bad). The block takes one reading per
// clock cycle unless the clearing sweep or a stalled output holds it; the
// registered read of the counter RAM is loaded at the accepting edge, and
// the update lands in the output register when the update stage moves on.
// Back-to-back readings of the same sensor run at full rate because the most
// recent RAM write is bypassed to the read side. After reset the block zeroes
// the counter RAM, one entry per cycle, so in_stall_o stays high until every
// entry is zeroed; configuration writes are taken during that time. The
// limits are inclusive and signed; a low limit above the high limit makes
// every reading bad. Readings from an id beyond the table leave the counters
// alone and report zero counts.
module sensor_health_classifier
  import shc_pkg::*;
#(
  parameter int unsigned NUM_SENSORS = 256,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [SAMPLE_W-1:0]        cfg_data_i,

  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ID_W-1:0]            sensor_id_i,
  input  logic signed [SAMPLE_W-1:0] reading_i,

  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ID_W-1:0]            sensor_id_out_o,
  output logic [1:0]                 status_o,
  output logic                       in_range_o,
  output logic [OUT_CNT_W-1:0]       bad_count_o,
  output logic [OUT_CNT_W-1:0]       total_count_o
);

  localparam int unsigned AW = (NUM_SENSORS > 1) ? $clog2(NUM_SENSORS) : 1;
  localparam int unsigned DW = 2 * COUNT_WIDTH;

  // Limit registers.
  logic signed [SAMPLE_W-1:0] low_limit_q;
  logic signed [SAMPLE_W-1:0] high_limit_q;

  // Input handshake and the range check at the time a word is taken.
  logic accept;
  logic id_hit;
  logic in_ok;

  // Update stage: the word whose counters are being read from the RAM.
  logic            s1_valid_q;
  logic [ID_W-1:0] s1_id_q;
  logic            s1_ok_q;
  logic            s1_hit_q;
  logic            advance;

  // RAM ports.
  logic          clr_busy;
  logic [DW-1:0] cur_entry;
  logic          mem_we;
  logic [DW-1:0] new_entry;

  logic [COUNT_WIDTH-1:0] cur_total;
  logic [COUNT_WIDTH-1:0] cur_bad;
  logic [COUNT_WIDTH-1:0] new_total;
  logic [COUNT_WIDTH-1:0] new_bad;
  status_e                new_status;

  // Output register.
  logic                 out_valid_q;
  logic [ID_W-1:0]      out_id_q;
  status_e              out_status_q;
  logic                 out_ok_q;
  logic [OUT_CNT_W-1:0] out_bad_q;
  logic [OUT_CNT_W-1:0] out_total_q;

  // Configuration is always accepted; writes to either limit land at once.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_limit_q  <= LOW_LIMIT_RST;
      high_limit_q <= HIGH_LIMIT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LOW_LIMIT:  low_limit_q  <= cfg_data_i;
        CFG_HIGH_LIMIT: high_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The update stage moves on when the output register is empty or is being
  // drained in this cycle. A word is taken whenever the stage moves on or is
  // empty, except during the clearing sweep.
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = clr_busy || (s1_valid_q && !advance);
  assign accept     = in_valid_i && !in_stall_o;

  assign id_hit = (32'(sensor_id_i) < NUM_SENSORS);
  assign in_ok  = (reading_i >= low_limit_q) && (reading_i <= high_limit_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_id_q  <= sensor_id_i;
      s1_ok_q  <= in_ok;
      s1_hit_q <= id_hit;
    end
  end

  // Each RAM entry holds the bad count above the total count.
  shc_count_mem #(
    .DEPTH (NUM_SENSORS),
    .AW    (AW),
    .DW    (DW)
  ) u_count_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept && id_hit),
    .rd_addr_i  (AW'(sensor_id_i)),
    .wr_en_i    (mem_we),
    .wr_addr_i  (AW'(s1_id_q)),
    .wr_data_i  (new_entry),
    .clr_busy_o (clr_busy),
    .rd_data_o  (cur_entry)
  );

  assign cur_total = cur_entry[COUNT_WIDTH-1:0];
  assign cur_bad   = cur_entry[DW-1:COUNT_WIDTH];

  // Saturating increments; the bad count only moves on an out-of-range word.
  always_comb begin
    new_total = (cur_total == '1) ? cur_total : cur_total + COUNT_WIDTH'(1);
    if (s1_ok_q || (cur_bad == '1)) begin
      new_bad = cur_bad;
    end else begin
      new_bad = cur_bad + COUNT_WIDTH'(1);
    end
    if (!s1_hit_q || (new_bad == '0)) begin
      new_status = STATUS_OK;
    end else if (new_bad < new_total) begin
      new_status = STATUS_PROBLEMS;
    end else begin
      new_status = STATUS_DEFECT;
    end
  end

  assign mem_we    = advance && s1_hit_q;
  assign new_entry = {new_bad, new_total};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_id_q     <= s1_id_q;
      out_status_q <= new_status;
      out_ok_q     <= s1_ok_q;
      out_bad_q    <= s1_hit_q ? OUT_CNT_W'(new_bad) : '0;
      out_total_q  <= s1_hit_q ? OUT_CNT_W'(new_total) : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sensor_id_out_o = out_id_q;
  assign status_o        = out_status_q;
  assign in_range_o      = out_ok_q;
  assign bad_count_o     = out_bad_q;
  assign total_count_o   = out_total_q;

`ifndef SYNTHESIS
  // A sensor reported as fully defective has equal counts.
  a_defect_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STATUS_DEFECT)) |-> (bad_count_o == total_count_o))
    else $error("defect status with unequal counts");

  // A zero bad count can only be reported with ok status.
  a_ok_when_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (COUNT_WIDTH <= OUT_CNT_W) && (bad_count_o == '0))
      |-> (status_o == STATUS_OK))
    else $error("nonzero status with zero bad count");

  // No reading reaches the update stage while the RAM is being cleared.
  a_no_work_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !clr_busy)
    else $error("update stage busy during clearing sweep");

  // A RAM write only comes from a word leaving the update stage.
  a_write_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> out_valid_q)
    else $error("counter write without a result");
`endif

endmodule

// File: src/shc_count_mem.sv
// Counter table: one synchronous RAM with a registered read port, a clearing
// sweep after reset, and a one-entry bypass of the most recent write.
module shc_count_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8,
  parameter int unsigned DW    = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [DW-1:0] wr_data_i,
  output logic          clr_busy_o,
  output logic [DW-1:0] rd_data_o
);

  logic [DW-1:0] mem [DEPTH];

  logic          clr_busy_q;
  logic [AW-1:0] clr_addr_q;

  logic          we;
  logic [AW-1:0] wa;
  logic [DW-1:0] wd;

  logic [DW-1:0] rd_q;
  logic [AW-1:0] rd_addr_q;

  logic          fwd_valid_q;
  logic [AW-1:0] fwd_addr_q;
  logic [DW-1:0] fwd_data_q;

  // The sweep owns the write port until every entry has been zeroed.
  always_comb begin
    we = clr_busy_q | wr_en_i;
    wa = clr_busy_q ? clr_addr_q : wr_addr_i;
    wd = clr_busy_q ? '0 : wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q      <= mem[rd_addr_i];
      rd_addr_q <= rd_addr_i;
    end
  end

  // The last write is the newest value of its entry. A read issued at the
  // same edge as that write sees the old contents, so the bypass wins.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else if (we) begin
      fwd_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      fwd_addr_q <= wa;
      fwd_data_q <= wd;
    end
  end

  assign clr_busy_o = clr_busy_q;
  assign rd_data_o  = (fwd_valid_q && (fwd_addr_q == rd_addr_q)) ? fwd_data_q : rd_q;

endmodule
